// ===== hw/rtl/fundamental_peak_picker_defines.svh =====
// Assertion macros for the checking file of the peak picker.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FUNDAMENTAL_PEAK_PICKER_DEFINES_SVH
`define FUNDAMENTAL_PEAK_PICKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fpp_pkg.sv =====
package fpp_pkg;

  // Default build sizes.
  localparam int DEF_MAX_ORDER   = 8;
  localparam int DEF_MAX_PEAKS   = 8;
  localparam int DEF_MAX_BINS    = 4096;
  localparam int DEF_VALUE_WIDTH = 24;

  // Fixed register widths.
  localparam int ORDER_W   = 4;
  localparam int PEAKS_W   = 4;
  localparam int RATIO_W   = 16;
  localparam int CFG_IDX_W = 2;

  // The rejection ratio is an unsigned 8.8 number.
  localparam int RATIO_FRAC = 8;

  // Register reset values.
  localparam logic [ORDER_W-1:0] RST_ORDER = 4'd1;
  localparam logic [PEAKS_W-1:0] RST_PEAKS = 4'd8;
  localparam logic [RATIO_W-1:0] RST_RATIO = 16'd256;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE = 2'd0,
    REG_ORDER = 2'd1,
    REG_PEAKS = 2'd2,
    REG_RATIO = 2'd3
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_JUDGE,
    S_SCAN,
    S_COMMIT,
    S_MAX,
    S_SURV,
    S_FLUSH,
    S_EMIT
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic judge;
    logic scan_step;
    logic commit;
    logic max_step;
    logic surv_step;
    logic emit;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic peak_hit;
    logic last_item;
    logic slot_free;
    logic slot_end;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/fpp_datapath.sv =====
module fpp_datapath #(
  parameter int MAX_ORDER   = 8,
  parameter int MAX_PEAKS   = 8,
  parameter int MAX_BINS    = 4096,
  parameter int VALUE_WIDTH = 24,
  localparam int SLOT_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1,
  localparam int IDX_W  = $clog2(MAX_BINS + 1),
  localparam int CFG_W  = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fpp_pkg::cmd_t                     cmd,
  input  logic [SLOT_W-1:0]                 slot,
  output fpp_pkg::stat_t                    stat,
  input  logic                              cfg_valid,
  input  logic [fpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data,
  input  logic [VALUE_WIDTH-1:0]            in_rank,
  input  logic [VALUE_WIDTH-1:0]            in_shape,
  input  logic                              in_last,
  output logic                              out_valid,
  output logic [IDX_W-1:0]                  out_index,
  output logic                              out_found,
  input  logic                              out_ready
);
  import fpp_pkg::*;

  localparam int WIN_D   = 2 * MAX_ORDER + 1;
  localparam int RANK_D  = MAX_ORDER + 1;
  localparam int WIN_IW  = $clog2(WIN_D);
  localparam int ORD_W   = $clog2(MAX_ORDER + 1);
  localparam int BIN_W   = $clog2(MAX_BINS);
  localparam int PROD_W  = RATIO_W + VALUE_WIDTH;

  // Configuration registers.
  logic [VALUE_WIDTH-1:0] noise_r;
  logic [ORDER_W-1:0]     order_r;
  logic [PEAKS_W-1:0]     peaks_r;
  logic [RATIO_W-1:0]     ratio_r;

  // Bin history and per-bin context.
  logic [VALUE_WIDTH-1:0] win_r  [WIN_D];
  logic [VALUE_WIDTH-1:0] rank_r [RANK_D];
  logic [BIN_W-1:0]       bin_count_r;
  logic [BIN_W-1:0]       k_r;
  logic [ORD_W-1:0]       ord_r;
  logic                   last_r;

  // Candidate peak and slot search.
  logic [BIN_W-1:0]       cand_bin_r;
  logic [VALUE_WIDTH-1:0] cand_rank_r;
  logic [VALUE_WIDTH-1:0] cand_shape_r;
  logic [SLOT_W-1:0]      m_r;
  logic [VALUE_WIDTH-1:0] min_r;
  logic                   free_r;

  // Slot store.
  logic [BIN_W-1:0]       slot_bin_r   [MAX_PEAKS];
  logic [VALUE_WIDTH-1:0] slot_rank_r  [MAX_PEAKS];
  logic [VALUE_WIDTH-1:0] slot_shape_r [MAX_PEAKS];
  logic [MAX_PEAKS-1:0]   slot_used_r;

  // End-of-spectrum evaluation.
  logic [VALUE_WIDTH-1:0] big_r;
  logic [PROD_W-1:0]      prod_r;
  logic [BIN_W-1:0]       pbin_r;
  logic                   pok_r;
  logic                   pvld_r;
  logic [IDX_W-1:0]       best_r;
  logic                   found_r;

  // Result register.
  logic                   out_valid_r;
  logic [IDX_W-1:0]       out_index_r;
  logic                   out_found_r;

  logic                   last_in;
  logic [ORD_W-1:0]       ord_eff;
  logic [SLOT_W-1:0]      use_m1;
  logic                   used_j;
  logic [VALUE_WIDTH-1:0] rank_j;
  logic [VALUE_WIDTH-1:0] shape_j;
  logic [BIN_W-1:0]       bin_j;
  logic                   peak_hit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= '0;
      order_r <= RST_ORDER;
      peaks_r <= RST_PEAKS;
      ratio_r <= RST_RATIO;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NOISE: noise_r <= cfg_data[VALUE_WIDTH-1:0];
        REG_ORDER: order_r <= cfg_data[ORDER_W-1:0];
        REG_PEAKS: peaks_r <= cfg_data[PEAKS_W-1:0];
        REG_RATIO: ratio_r <= cfg_data[RATIO_W-1:0];
      endcase
    end
  end

  // Effective order and slot count, clamped to the built sizes.
  always_comb begin
    if (32'(order_r) > MAX_ORDER) begin
      ord_eff = ORD_W'(MAX_ORDER);
    end else begin
      ord_eff = ORD_W'(order_r);
    end
    if (peaks_r == '0) begin
      use_m1 = '0;
    end else if (32'(peaks_r) > MAX_PEAKS) begin
      use_m1 = SLOT_W'(MAX_PEAKS - 1);
    end else begin
      use_m1 = SLOT_W'(32'(peaks_r) - 1);
    end
  end

  // A spectrum that runs to the bin limit ends there.
  assign last_in = in_last || (bin_count_r == BIN_W'(MAX_BINS - 1));

  // Peak test on the centre bin: threshold plus non-rising flanks.
  always_comb begin
    peak_hit = (32'(k_r) >= 2 * 32'(ord_r)) && (win_r[WIN_IW'(ord_r)] >= noise_r);
    for (int i = 0; i < 2 * MAX_ORDER; i++) begin
      if ((i < 32'(ord_r)) && (win_r[i+1] < win_r[i])) begin
        peak_hit = 1'b0;
      end
      if ((i >= 32'(ord_r)) && (i < 2 * 32'(ord_r)) && (win_r[i] < win_r[i+1])) begin
        peak_hit = 1'b0;
      end
    end
  end

  // Slot selected by the sequencer.
  assign used_j  = slot_used_r[slot];
  assign rank_j  = slot_rank_r[slot];
  assign shape_j = slot_shape_r[slot];
  assign bin_j   = slot_bin_r[slot];

  // Status back to the sequencer.
  always_comb begin
    stat.peak_hit  = peak_hit;
    stat.last_item = last_r;
    stat.slot_free = !used_j;
    stat.slot_end  = (slot == use_m1);
    stat.out_busy  = out_valid_r;
  end

  // Bin history shifts on each accepted request.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_r[0]  <= in_shape;
      rank_r[0] <= in_rank;
      for (int i = 1; i < WIN_D; i++) begin
        win_r[i] <= win_r[i-1];
      end
      for (int i = 1; i < RANK_D; i++) begin
        rank_r[i] <= rank_r[i-1];
      end
      k_r    <= bin_count_r;
      ord_r  <= ord_eff;
      last_r <= last_in;
    end
  end

  // Bin counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= '0;
    end else if (cmd.accept) begin
      bin_count_r <= last_in ? '0 : bin_count_r + 1'b1;
    end
  end

  // Candidate capture and the search for a free or weakest slot.
  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      cand_bin_r   <= k_r - BIN_W'(ord_r);
      cand_rank_r  <= rank_r[ord_r];
      cand_shape_r <= win_r[WIN_IW'(ord_r)];
      free_r       <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!used_j) begin
        m_r    <= slot;
        free_r <= 1'b1;
      end else if ((slot == '0) || (rank_j < min_r)) begin
        m_r   <= slot;
        min_r <= rank_j;
      end
    end
  end

  // Slot payload is written only when the candidate wins a slot.
  always_ff @(posedge clk) begin
    if (cmd.commit && (free_r || (cand_rank_r > min_r))) begin
      slot_bin_r[m_r]   <= cand_bin_r;
      slot_rank_r[m_r]  <= cand_rank_r;
      slot_shape_r[m_r] <= cand_shape_r;
    end
  end

  // Slot occupancy, cleared when the result is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else if (cmd.emit) begin
      slot_used_r <= '0;
    end else if (cmd.commit && (free_r || (cand_rank_r > min_r))) begin
      slot_used_r[m_r] <= 1'b1;
    end
  end

  // Largest kept shape, then ratio products one slot per cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      big_r <= '0;
    end else if (cmd.max_step && used_j && (shape_j > big_r)) begin
      big_r <= shape_j;
    end
    if (cmd.surv_step) begin
      prod_r <= PROD_W'(ratio_r) * PROD_W'(shape_j);
      pbin_r <= bin_j;
      pok_r  <= used_j;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.surv_step;
    end
  end

  // Survivor compare on the registered product; keep the lowest bin.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      best_r  <= IDX_W'(bin_count_r) + 1'b1;
      found_r <= 1'b0;
    end else if (pvld_r && pok_r && (prod_r >= (PROD_W'(big_r) << RATIO_FRAC))) begin
      found_r <= 1'b1;
      if (IDX_W'(pbin_r) < best_r) begin
        best_r <= IDX_W'(pbin_r);
      end
    end
  end

  // Result register, held until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index_r <= best_r;
      out_found_r <= found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_found = out_found_r;

endmodule

// ===== hw/rtl/fpp_ctrl.sv =====
module fpp_ctrl #(
  parameter int MAX_PEAKS = 8,
  localparam int SLOT_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fpp_pkg::stat_t    stat,
  output fpp_pkg::cmd_t     cmd,
  output logic [SLOT_W-1:0] slot
);
  import fpp_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;

  // State and slot counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Next state and slot walk.
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        slot_nxt = '0;
        priority if (stat.peak_hit) begin
          state_nxt = S_SCAN;
        end else if (stat.last_item) begin
          state_nxt = S_MAX;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.slot_free || stat.slot_end) begin
          state_nxt = S_COMMIT;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_COMMIT: begin
        slot_nxt  = '0;
        state_nxt = stat.last_item ? S_MAX : S_IDLE;
      end
      S_MAX: begin
        if (stat.slot_end) begin
          slot_nxt  = '0;
          state_nxt = S_SURV;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_SURV: begin
        if (stat.slot_end) begin
          state_nxt = S_FLUSH;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_FLUSH: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_JUDGE:  cmd.judge     = 1'b1;
      S_SCAN:   cmd.scan_step = 1'b1;
      S_COMMIT: cmd.commit    = 1'b1;
      S_MAX:    cmd.max_step  = 1'b1;
      S_SURV:   cmd.surv_step = 1'b1;
      S_FLUSH:  cmd           = '0;
      S_EMIT:   cmd.emit      = !stat.out_busy;
    endcase
  end

  assign slot = slot_r;

endmodule

// ===== hw/rtl/fundamental_peak_picker.sv =====
// Fundamental peak picker. Spectrum bins stream in one request at a time (rank magnitude and
// shape magnitude in in_tdata, in_tlast on the final bin); the block keeps up to peaks_in_use
// candidate peaks and, on the final bin, returns one result: the lowest surviving peak bin, or
// the bin count with peak_found low. A bin with no peak to judge is taken and judged; a judged
// peak also walks the slots until a free one or the last slot in use is found, then commits.
// The final bin adds a maximum search, the survivor test, a flush and the emit, plus any wait
// for the previous result to leave. These steps are set by the single slot store, which is
// visited one slot per cycle for insertion, the maximum search and the survivor test. One bin
// is in flight at a time; in_tready is high only while the block is idle.
module fundamental_peak_picker #(
  parameter int MAX_ORDER   = fpp_pkg::DEF_MAX_ORDER,
  parameter int MAX_PEAKS   = fpp_pkg::DEF_MAX_PEAKS,
  parameter int MAX_BINS    = fpp_pkg::DEF_MAX_BINS,
  parameter int VALUE_WIDTH = fpp_pkg::DEF_VALUE_WIDTH,
  localparam int IN_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int IDX_W = $clog2(MAX_BINS + 1),
  localparam int OUT_W = ((IDX_W + 7) / 8) * 8,
  localparam int CFG_W = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,   // rank_value, shape_value
  input  logic                          in_tlast,   // last_bin
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,  // fundamental_index
  output logic                          out_tuser,  // peak_found
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);
  import fpp_pkg::*;

  localparam int SLOT_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

  cmd_t              cmd;
  stat_t             stat;
  logic [SLOT_W-1:0] slot;
  logic [IDX_W-1:0]  out_index;

  // Registers can be written at any time.
  assign cfg_ready = 1'b1;

  fpp_ctrl #(
    .MAX_PEAKS (MAX_PEAKS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd),
    .slot     (slot)
  );

  fpp_datapath #(
    .MAX_ORDER   (MAX_ORDER),
    .MAX_PEAKS   (MAX_PEAKS),
    .MAX_BINS    (MAX_BINS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .slot      (slot),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_rank   (in_tdata[VALUE_WIDTH-1:0]),
    .in_shape  (in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_index (out_index),
    .out_found (out_tuser),
    .out_ready (out_tready)
  );

  // Index in the low bits, zero padding above.
  assign out_tdata = OUT_W'(out_index);

endmodule

// ===== hw/rtl/fpp_checker.sv =====
`include "fundamental_peak_picker_defines.svh"

module fpp_checker #(
  parameter int MAX_BINS = 4096,
  localparam int IDX_W = $clog2(MAX_BINS + 1),
  localparam int OUT_W = ((IDX_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tuser
);

  // A stalled result keeps its contents.
  `FPP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // An accepted bin leaves the block busy in the cycle after it is taken.
  `FPP_ASSERT_NEXT(a_bin_busy, in_tvalid && in_tready, !in_tready, "input ready straight after a bin")

  // A new result is only loaded while the block is busy with a bin.
  `FPP_ASSERT_NOW(a_rise_busy, $rose(out_tvalid), $past(!in_tready), "result appeared while idle")

  // With no surviving peak the index is the bin count, never zero.
  `FPP_ASSERT_NOW(a_empty_index, out_tvalid && !out_tuser, out_tdata[IDX_W-1:0] != '0, "empty spectrum reported zero bins")

  // A surviving peak lies inside the spectrum.
  `FPP_ASSERT_NOW(a_peak_range, out_tvalid && out_tuser, 32'(out_tdata[IDX_W-1:0]) < MAX_BINS, "peak index beyond the bin limit")

endmodule

bind fundamental_peak_picker fpp_checker #(
  .MAX_BINS (MAX_BINS)
) u_fpp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
